// File: design/frp_pkg.sv
// Package for the fixed predictor Rice planner.
// Holds field widths, caps and the shared sequencer types; no dependencies.
package frp_pkg;

  localparam int unsigned SampleW   = 25;
  localparam int unsigned WidthW    = 5;
  localparam int unsigned OrderW    = 3;
  localparam int unsigned ParamW    = 5;
  localparam int unsigned BitsW     = 41;
  localparam int unsigned SumW      = 48;
  localparam int unsigned ZzW       = 30;
  localparam int unsigned BlockDepthDef = 4096;
  localparam int unsigned EstCap    = 28;
  localparam int unsigned ParamCap  = 30;
  localparam int unsigned MaxOrder  = 4;
  localparam int unsigned NumCand   = 4;

  // Sequencer states, one-hot.
  typedef enum logic [9:0] {
    StLoad   = 10'b0000000001,
    StOrdIni = 10'b0000000010,
    StSum    = 10'b0000000100,
    StDiv    = 10'b0000001000,
    StEst    = 10'b0000010000,
    StCost   = 10'b0000100000,
    StPick   = 10'b0001000000,
    StNext   = 10'b0010000000,
    StOut    = 10'b0100000000,
    StFlush  = 10'b1000000000
  } state_e;

  // Zigzag residual of order o from the current sample and up to four
  // earlier samples.
  function automatic logic [ZzW-1:0] zigzag(
    input logic [OrderW-1:0] o,
    input logic signed [SampleW-1:0] x0, x1, x2, x3, x4
  );
    logic signed [ZzW:0] p;
    logic signed [ZzW:0] r;
    logic signed [ZzW:0] a0, a1, a2, a3, a4;
    a1 = {{(ZzW+1-SampleW){x1[SampleW-1]}}, x1};
    a2 = {{(ZzW+1-SampleW){x2[SampleW-1]}}, x2};
    a3 = {{(ZzW+1-SampleW){x3[SampleW-1]}}, x3};
    a4 = {{(ZzW+1-SampleW){x4[SampleW-1]}}, x4};
    a0 = {{(ZzW+1-SampleW){x0[SampleW-1]}}, x0};
    unique case (o)
      3'd0: p = '0;
      3'd1: p = a1;
      3'd2: p = (a1 <<< 1) - a2;
      3'd3: p = (a1 <<< 1) + a1 - (a2 <<< 1) - a2 + a3;
      default: p = (a1 <<< 2) - (a2 <<< 2) - (a2 <<< 1) + (a3 <<< 2) - a4;
    endcase
    r = a0 - p;
    if (r[ZzW]) zigzag = {~r[ZzW-2:0], 1'b1};
    else        zigzag = {r[ZzW-2:0], 1'b0};
  endfunction

endpackage

// File: design/fixed_predictor_rice_planner.sv
// Fixed predictor Rice planner, top level.
// Depends on frp_pkg (widths, sequencer states, zigzag residual function).
//
//  channel | dir | handshake             | payload
//  s_axis  | in  | tvalid/tready         | tdata: sample[24:0]; tlast: last
//  m_axis  | out | tvalid/tready         | tdata: is_constant, order, param, bits
//  cfg     | in  | cfg_valid/cfg_ready   | cfg_data: sample_width[4:0]
//
// Samples load one per cycle into a block memory. On the last beat the
// sequencer replays the block: per order one pass to sum zigzag residuals, a
// 48-step restoring division for the mean, then one pass per candidate
// parameter (four at most), each pass reading through the registered memory port.
// Input ready is low from the last beat until the result beat is taken.
// Reset is asynchronous; the memory is not cleared.
module fixed_predictor_rice_planner #(
  parameter int unsigned BLOCK_DEPTH = frp_pkg::BlockDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [24:0] sample
  input  logic        s_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [0] is_constant, [3:1] order, [8:4] param,
                                      // [49:9] estimated_bits
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data        // [4:0] sample_width
);
  import frp_pkg::*;

  localparam int unsigned AW = $clog2(BLOCK_DEPTH);
  localparam int unsigned CW = AW + 1;

  logic signed [SampleW-1:0] mem_q [BLOCK_DEPTH];
  logic signed [SampleW-1:0] rd_q;
  logic [AW-1:0] rd_addr;
  logic          rd_en;

  state_e state_q, state_d;
  logic [WidthW-1:0] width_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic all_eq_q, all_eq_d;
  logic signed [SampleW-1:0] first_q, first_d;
  logic [OrderW-1:0] ord_q, ord_d;
  logic [CW-1:0] idx_q, idx_d;              // read pointer
  logic [CW-1:0] vcnt_q, vcnt_d;            // residuals consumed
  logic lat_q, lat_d;                       // read data valid
  logic signed [SampleW-1:0] h1_q, h2_q, h3_q, h4_q;
  logic [CW-1:0] hcnt_q, hcnt_d;            // samples shifted in
  logic [SumW-1:0] acc_q, acc_d;
  logic [SumW-1:0] quo_q, quo_d, rem_q, rem_d;
  logic [5:0] step_q, step_d;
  logic [ParamW-1:0] prm_q, prm_d, hi_q, hi_d;
  logic stop_q, stop_d;
  logic [SumW-1:0] obest_q, obest_d;
  logic [ParamW-1:0] oprm_q, oprm_d;
  logic [SumW-1:0] best_q, best_d;
  logic [OrderW-1:0] bord_q, bord_d;
  logic [ParamW-1:0] bprm_q, bprm_d;
  logic [55:0] out_q, out_d;
  logic out_v_q, out_v_d;

  logic in_fire, pass_done;
  logic [ZzW-1:0] zz;
  logic [CW-1:0] nord;
  logic [SumW-1:0] rsh, trial;
  logic [5:0] base;
  logic [7:0] warm;
  logic [SumW-1:0] with_warm;

  assign s_axis_tready = state_q == StLoad;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  // Block memory: one write port at load, one registered read port.
  assign rd_addr = idx_q[AW-1:0];
  assign rd_en   = state_q == StSum || state_q == StCost;
  always_ff @(posedge clk_i) begin
    if (in_fire && cnt_q < CW'(BLOCK_DEPTH)) mem_q[cnt_q[AW-1:0]] <= s_axis_tdata[SampleW-1:0];
    if (rd_en) rd_q <= mem_q[rd_addr];
  end

  // Residual from the read data and the four previous samples.
  assign zz   = zigzag(ord_q, rd_q, h1_q, h2_q, h3_q, h4_q);
  assign nord = cnt_q - CW'(ord_q);
  assign pass_done = vcnt_q == nord;
  assign rsh  = SumW'(zz >> prm_q) + SumW'(prm_q) + SumW'(1);
  assign trial = {rem_q[SumW-2:0], quo_q[SumW-1]} - SumW'(nord);
  assign warm = 8'(ord_q) * 8'(width_q);
  assign with_warm = obest_q + SumW'(warm);

  always_comb begin
    base = '0;
    for (int b = 0; b < EstCap; b++) if (quo_q[b]) base = 6'(b + 1);
    if (quo_q[SumW-1:EstCap] != '0) base = 6'(EstCap);
  end

  // Sequencer.
  always_comb begin
    state_d = state_q; cnt_d = cnt_q; all_eq_d = all_eq_q; first_d = first_q;
    ord_d = ord_q; idx_d = idx_q; vcnt_d = vcnt_q; lat_d = lat_q; hcnt_d = hcnt_q;
    acc_d = acc_q; quo_d = quo_q; rem_d = rem_q; step_d = step_q; prm_d = prm_q;
    hi_d = hi_q; stop_d = stop_q; obest_d = obest_q; oprm_d = oprm_q;
    best_d = best_q; bord_d = bord_q; bprm_d = bprm_q; out_d = out_q;
    out_v_d = out_v_q;
    if (out_v_q && m_axis_tready) out_v_d = 1'b0;
    unique case (state_q)
      StLoad: if (in_fire) begin
        if (cnt_q < CW'(BLOCK_DEPTH)) begin
          if (cnt_q == '0) first_d = s_axis_tdata[SampleW-1:0];
          else if (s_axis_tdata[SampleW-1:0] != first_q) all_eq_d = 1'b0;
          cnt_d = cnt_q + 1'b1;
        end
        if (s_axis_tlast) begin
          if (all_eq_d) begin
            out_d = {6'd0, BitsW'(width_q), 8'd0, 1'b1};
            state_d = StOut;
          end else begin
            ord_d = '0; best_d = '1; bord_d = '0; bprm_d = '0;
            state_d = StOrdIni;
          end
        end
      end
      StOrdIni: begin
        idx_d = '0; vcnt_d = '0; lat_d = '0; hcnt_d = '0; acc_d = '0; stop_d = 1'b0;
        state_d = StSum;
      end
      StSum, StCost: begin
        lat_d = idx_q < cnt_q;
        if (idx_q < cnt_q) idx_d = idx_q + 1'b1;
        if (lat_q) begin
          hcnt_d = hcnt_q + 1'b1;
          if (hcnt_q >= CW'(ord_q)) begin
            vcnt_d = vcnt_q + 1'b1;
            if (state_q == StSum) acc_d = acc_q + SumW'(zz);
            else if (!stop_q) begin
              acc_d = acc_q + rsh;
              if (acc_d > (SumW'(1) << 40)) stop_d = 1'b1;
            end
          end
        end
        if (pass_done) begin
          if (state_q == StSum) begin
            quo_d = acc_q; rem_d = '0; step_d = '0; state_d = StDiv;
          end else state_d = StPick;
        end
      end
      StDiv: begin
        rem_d = {rem_q[SumW-2:0], quo_q[SumW-1]};
        quo_d = {quo_q[SumW-2:0], 1'b0};
        if (!trial[SumW-1] || rem_q[SumW-1]) begin
          rem_d = trial; quo_d[0] = 1'b1;
        end
        step_d = step_q + 1'b1;
        if (step_q == 6'(SumW - 1)) state_d = StEst;
      end
      StEst: begin
        prm_d = base > 6'd2 ? ParamW'(base - 6'd2) : '0;
        hi_d  = base + 6'd1 < 6'(ParamCap) ? ParamW'(base + 6'd1) : ParamW'(ParamCap);
        obest_d = '1; oprm_d = '0;
        idx_d = '0; vcnt_d = '0; lat_d = '0; hcnt_d = '0; acc_d = '0; stop_d = 1'b0;
        state_d = StCost;
      end
      StPick: begin
        if (acc_q < obest_q) begin obest_d = acc_q; oprm_d = prm_q; end
        if (prm_q == hi_q) state_d = StNext;
        else begin
          prm_d = prm_q + 1'b1;
          idx_d = '0; vcnt_d = '0; lat_d = '0; hcnt_d = '0; acc_d = '0; stop_d = 1'b0;
          state_d = StCost;
        end
      end
      StNext: begin
        if (with_warm < best_q) begin
          best_d = with_warm; bord_d = ord_q; bprm_d = oprm_q;
        end
        if (ord_q == OrderW'(MaxOrder) || CW'(ord_q) + 1'b1 >= cnt_q) begin
          out_d = {6'd0,
                   (best_d > SumW'({BitsW{1'b1}})) ? {BitsW{1'b1}} : best_d[BitsW-1:0],
                   bprm_d, bord_d, 1'b0};
          state_d = StOut;
        end else begin
          ord_d = ord_q + 1'b1;
          state_d = StOrdIni;
        end
      end
      StOut: if (!out_v_q) begin
        out_v_d = 1'b1; cnt_d = '0; all_eq_d = 1'b1; state_d = StFlush;
      end
      StFlush: if (!out_v_d) state_d = StLoad;
      default: state_d = StLoad;
    endcase
  end

  // Sample history for the predictor and the datapath registers, without reset.
  always_ff @(posedge clk_i) begin
    if ((state_q == StSum || state_q == StCost) && lat_q) begin
      h1_q <= rd_q; h2_q <= h1_q; h3_q <= h2_q; h4_q <= h3_q;
    end
    first_q <= first_d; ord_q <= ord_d; idx_q <= idx_d; vcnt_q <= vcnt_d;
    hcnt_q <= hcnt_d; acc_q <= acc_d; quo_q <= quo_d; rem_q <= rem_d;
    step_q <= step_d; prm_q <= prm_d; hi_q <= hi_d; stop_q <= stop_d;
    obest_q <= obest_d; oprm_q <= oprm_d; best_q <= best_d; bord_q <= bord_d;
    bprm_q <= bprm_d; out_q <= out_d; lat_q <= lat_d;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad; cnt_q <= '0; all_eq_q <= 1'b1; width_q <= WidthW'(16);
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; all_eq_q <= all_eq_d; out_v_q <= out_v_d;
      if (cfg_valid && cfg_ready) width_q <= cfg_data[WidthW-1:0];
    end
  end

  // Checks.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(BLOCK_DEPTH)) else $error("sample count overflow");
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> !s_axis_tready || state_q == StLoad) else $error("load while busy");
  a_param_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> out_q[8:4] <= 5'(ParamCap)) else $error("param above cap");
  a_order_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> out_q[3:1] <= 3'(MaxOrder)) else $error("order above cap");

endmodule
